>>> hw/rtl/wsa_pkg.sv
// wsa_pkg: shared widths, register and mode codes, structs and helper functions
// for the waveform sample averager; used by every module but wsa_queue
// no dependencies

package wsa_pkg;

    localparam int SMP_W      = 8;
    localparam int ACC_W      = 16;
    localparam int K_W        = 4;
    localparam int CNT_W      = 9;
    localparam int DIV_W      = CNT_W + 1;
    localparam int PT_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int FRAME_POINTS_DEF = 1024;
    localparam int COUNT_CAP_DEF    = 266;
    localparam int CHANNELS_DEF     = 2;

    // front-to-back queue and result queue depths
    localparam int FQ_DEPTH = 4;
    localparam int OQ_DEPTH = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AVG_EXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RND_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RND_EXP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING  = 2'd3;

    // per-sample work classes
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_ACCUM = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;
    localparam logic [1:0] MODE_EMA   = 2'd3;

    typedef struct packed {
        logic [K_W-1:0]   avg_exp;
        logic             rnd_mode;
        logic [K_W-1:0]   rnd_exp;
        logic [SMP_W-1:0] missing;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [K_W-1:0]   k;
        logic [CNT_W-1:0] count;
        logic [SMP_W-1:0] smp;
        logic             fend;
    } work_t;

    typedef struct packed {
        logic             byp;
        logic [ACC_W-1:0] dq;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic             fend;
    } divw_t;

    typedef struct packed {
        logic [SMP_W-1:0] avg;
        logic             fend;
    } res_t;

    // point index reduced into the frame by shifted conditional subtracts
    function automatic logic [PT_W-1:0] pt_reduce(input logic [PT_W-1:0] pt, input int fp);
        int r;
        int sub;
        r = int'(pt);
        if (fp < (1 << PT_W))
        begin
            for (int j = PT_W - 1; j >= 0; j--)
            begin
                sub = fp << j;
                if (sub < (1 << PT_W) && r >= sub)
                begin
                    r = r - sub;
                end
            end
        end
        return PT_W'(r);
    endfunction

    // one restoring division step, one quotient bit
    function automatic divw_t div_step(input divw_t x);
        divw_t            y;
        logic [DIV_W:0]   t;
        y = x;
        t = {x.rem, x.dq[ACC_W-1]};
        if (!x.byp)
        begin
            if (t >= {1'b0, x.dvs})
            begin
                y.rem = DIV_W'(t - {1'b0, x.dvs});
                y.dq  = {x.dq[ACC_W-2:0], 1'b1};
            end
            else
            begin
                y.rem = t[DIV_W-1:0];
                y.dq  = {x.dq[ACC_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage

>>> hw/rtl/wsa_queue.sv
// wsa_queue: small register fifo used between front and back and for results
// depends on nothing but its parameters

module wsa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             head,
    output logic                         nonempty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CQ_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CQ_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CQ_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head     = data_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == CQ_W'(DEPTH));
    assign count    = count_reg;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CQ_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

>>> hw/rtl/wsa_front.sv
// wsa_front: accepts samples, keeps per-channel frame counts and classifies
// each sample into its averaging phase; uses wsa_pkg

module wsa_front
    import wsa_pkg::*;
#(
    parameter int FRAME_POINTS = FRAME_POINTS_DEF,
    parameter int COUNT_CAP    = COUNT_CAP_DEF,
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int SLOT_W       = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic              channel,
    input  logic [PT_W-1:0]   point_index,
    input  logic [SMP_W-1:0]  sample,
    input  logic              frame_end,
    input  logic              full,
    output logic              push,
    output logic [SLOT_W-1:0] push_slot,
    output work_t             push_work
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CNT_W-1:0] frames_reg [CHANNELS];
    logic [CNT_W-1:0] frames_next [CHANNELS];

    logic              accept;
    logic [CH_W-1:0]   ch_idx;
    logic [PT_W-1:0]   pt_red;
    logic [CNT_W-1:0]  count;
    logic [K_W-1:0]    k;
    logic              below;
    logic [1:0]        mode;
    logic              all_zero;
    logic              any_over;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign ch_idx   = (CHANNELS == 1) ? '0 : CH_W'(channel);
    assign pt_red   = pt_reduce(point_index, FRAME_POINTS);
    assign count    = frames_reg[ch_idx];

    always_comb
    begin
        k = cfg.avg_exp;
        if (cfg.rnd_mode && cfg.rnd_exp > cfg.avg_exp)
        begin
            k = cfg.rnd_exp;
        end
        below = ({{(ACC_W - CNT_W){1'b0}}, count} < (ACC_W'(1) << k));
        if (!below)
        begin
            mode = MODE_EMA;
        end
        else if (count == '0)
        begin
            mode = MODE_FIRST;
        end
        else if (sample == cfg.missing)
        begin
            mode = MODE_PASS;
        end
        else
        begin
            mode = MODE_ACCUM;
        end
    end

    assign push            = accept && !opcode;
    assign push_slot       = SLOT_W'(int'(ch_idx) * FRAME_POINTS + int'(pt_red));
    assign push_work.mode  = mode;
    assign push_work.k     = k;
    assign push_work.count = count;
    assign push_work.smp   = sample;
    assign push_work.fend  = frame_end;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            frames_next[c] = frames_reg[c];
            if (accept && opcode)
            begin
                frames_next[c] = '0;
            end
            else if (accept && frame_end && ch_idx == CH_W'(c)
                     && count < CNT_W'(COUNT_CAP))
            begin
                frames_next[c] = CNT_W'(count + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                frames_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                frames_reg[c] <= frames_next[c];
            end
        end
    end

    always_comb
    begin
        all_zero = 1'b1;
        any_over = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (frames_reg[c] != '0)
            begin
                all_zero = 1'b0;
            end
            if (frames_reg[c] > CNT_W'(COUNT_CAP))
            begin
                any_over = 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode |=> all_zero)
        else $error("restart left a frame count set");
    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        !any_over)
        else $error("frame count beyond cap");
    a_restart_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !opcode && !full)
        else $error("restart or stalled sample sent to back end");
`endif

endmodule

>>> hw/rtl/wsa_div.sv
// wsa_div: pipelined restoring divider, one quotient bit per stage, with a
// bypass for results that need no division; uses wsa_pkg

module wsa_div
    import wsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  divw_t in_item,
    output logic  res_valid,
    output res_t  res
);

    localparam int STAGES = ACC_W;

    logic  v_reg  [STAGES];
    divw_t d_reg  [STAGES];
    divw_t st_in  [STAGES];

    always_comb
    begin
        st_in[0] = in_item;
        for (int j = 1; j < STAGES; j++)
        begin
            st_in[j] = d_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < STAGES; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int j = 1; j < STAGES; j++)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            d_reg[j] <= div_step(st_in[j]);
        end
    end

    assign res_valid = v_reg[STAGES-1];
    assign res.avg   = d_reg[STAGES-1].dq[SMP_W-1:0];
    assign res.fend  = d_reg[STAGES-1].fend;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && !d_reg[STAGES-1].byp |->
            d_reg[STAGES-1].rem < d_reg[STAGES-1].dvs)
        else $error("division remainder not below divisor");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_item.byp |-> in_item.dvs > DIV_W'(1))
        else $error("division by less than two");
    a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |=> v_reg[0])
        else $error("divider lost an item");
`endif

endmodule

>>> hw/rtl/wsa_back.sv
// wsa_back: accumulator memory read-modify-write, one sample per cycle while go is
// high, with forwarding of the last write; feeds wsa_div; uses wsa_pkg

module wsa_back
    import wsa_pkg::*;
#(
    parameter int SLOT_W = 11,
    parameter int DEPTH  = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  logic [SLOT_W-1:0] head_slot,
    input  work_t             head_work,
    input  logic              go,
    output logic              pop,
    output logic              res_valid,
    output res_t              res
);

    logic [ACC_W-1:0]  mem [DEPTH];
    logic [ACC_W-1:0]  rd_data_reg;

    logic              s1_valid_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    work_t             s1_work_reg;

    logic              fwd_valid_reg;
    logic [SLOT_W-1:0] fwd_slot_reg;
    logic [ACC_W-1:0]  fwd_data_reg;

    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  smp_ext;
    logic [ACC_W-1:0]  new_acc;
    logic              wr_en;
    divw_t             div_in;

    assign pop     = head_valid && go;
    assign smp_ext = {{(ACC_W - SMP_W){1'b0}}, s1_work_reg.smp};

    // a write from the cycle before is not yet visible in the read data
    assign acc = (fwd_valid_reg && fwd_slot_reg == s1_slot_reg) ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        new_acc     = acc;
        wr_en       = 1'b0;
        div_in.byp  = 1'b1;
        div_in.dq   = smp_ext;
        div_in.rem  = '0;
        div_in.dvs  = DIV_W'(s1_work_reg.count) + DIV_W'(1);
        div_in.fend = s1_work_reg.fend;
        case (s1_work_reg.mode)
            MODE_FIRST:
            begin
                new_acc   = smp_ext;
                wr_en     = s1_valid_reg;
                div_in.dq = smp_ext;
            end
            MODE_ACCUM:
            begin
                new_acc    = ACC_W'(acc + smp_ext);
                wr_en      = s1_valid_reg;
                div_in.byp = 1'b0;
                div_in.dq  = new_acc;
            end
            MODE_EMA:
            begin
                new_acc   = ACC_W'(acc - (acc >> s1_work_reg.k) + smp_ext);
                wr_en     = s1_valid_reg;
                div_in.dq = new_acc >> s1_work_reg.k;
            end
            default:
            begin
                // missing sample: passed through, accumulator untouched
                div_in.dq = smp_ext;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= mem[head_slot];
        end
        if (wr_en)
        begin
            mem[s1_slot_reg] <= new_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= pop;
            fwd_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_slot_reg <= head_slot;
            s1_work_reg <= head_work;
        end
        fwd_slot_reg <= s1_slot_reg;
        fwd_data_reg <= new_acc;
    end

    wsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_item  (div_in),
        .res_valid(res_valid),
        .res      (res)
    );

`ifndef SYNTH
    a_accum_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_work_reg.mode == MODE_ACCUM |-> s1_work_reg.count != '0)
        else $error("accumulation with zero frame count");
    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> fwd_valid_reg && fwd_slot_reg == $past(s1_slot_reg))
        else $error("forwarding register missed a write");
    a_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_valid_reg && s1_work_reg.mode != MODE_PASS)
        else $error("accumulator written without a sample");
`endif

endmodule

>>> hw/rtl/waveform_sample_averager_core.sv
// waveform_sample_averager_core: top level of the per-point waveform averager
// depends on wsa_pkg, wsa_queue, wsa_front, wsa_back (wsa_div)
//
// usage:
//   input channel: in_valid/in_stall with opcode, channel, point_index, sample,
//   frame_end; a transfer happens when in_valid is high and in_stall low.
//   opcode 1 restarts averaging (frame counts of all channels cleared) and
//   gives no result; opcode 0 gives exactly one result.
//   output channel: out_valid/out_stall with averaged_sample and frame_done.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, write only while no sample is in flight.
//   throughput: one sample per clock when nothing stalls; the accumulator memory has
//   one read and one write port, and a write is forwarded to the sample right behind it.
//   path: an accepted sample passes the front queue, the read stage, the
//   16-stage divider and the result queue before out_valid rises.
//   reset: configuration and frame counts go to zero, queues empty; the
//   accumulator memory is not cleared, the first frame writes it.
//   stall: a held output fills the 32-entry result queue; the back end issues
//   only against free result slots, the 4-entry front queue then fills and
//   in_stall rises. nothing is dropped.

module waveform_sample_averager_core
    import wsa_pkg::*;
#(
    parameter int FRAME_POINTS = FRAME_POINTS_DEF,
    parameter int COUNT_CAP    = COUNT_CAP_DEF,
    parameter int CHANNELS     = CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic                  channel,
    input  logic [PT_W-1:0]       point_index,
    input  logic [SMP_W-1:0]      sample,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SMP_W-1:0]      averaged_sample,
    output logic                  frame_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = CHANNELS * FRAME_POINTS;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FQ_W   = SLOT_W + $bits(work_t);
    localparam int OQ_W   = $bits(res_t);
    localparam int CR_W   = $clog2(OQ_DEPTH + 1);

    cfg_t              cfg_reg;
    logic [CR_W-1:0]   credit_reg, credit_next;

    logic              f_push;
    logic [SLOT_W-1:0] f_slot;
    work_t             f_work;
    logic              fq_full;
    logic              fq_nonempty;
    logic [FQ_W-1:0]   fq_head;
    logic              fq_pop;
    logic              go;

    logic              d_valid;
    res_t              d_res;
    res_t              oq_head;
    logic              oq_full;
    logic [CR_W-1:0]   oq_count;
    logic              out_xfer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AVG_EXP:  cfg_reg.avg_exp  <= cfg_data[K_W-1:0];
                REG_RND_MODE: cfg_reg.rnd_mode <= cfg_data[0];
                REG_RND_EXP:  cfg_reg.rnd_exp  <= cfg_data[K_W-1:0];
                REG_MISSING:  cfg_reg.missing  <= cfg_data[SMP_W-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    wsa_front #(
        .FRAME_POINTS(FRAME_POINTS),
        .COUNT_CAP   (COUNT_CAP),
        .CHANNELS    (CHANNELS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .channel    (channel),
        .point_index(point_index),
        .sample     (sample),
        .frame_end  (frame_end),
        .full       (fq_full),
        .push       (f_push),
        .push_slot  (f_slot),
        .push_work  (f_work)
    );

    wsa_queue #(
        .WIDTH(FQ_W),
        .DEPTH(FQ_DEPTH)
    ) u_fq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_data({f_slot, f_work}),
        .pop      (fq_pop),
        .head     (fq_head),
        .nonempty (fq_nonempty),
        .full     (fq_full),
        .count    ()
    );

    // issue only against a free result slot, so the back end never stalls
    assign go = (credit_reg < CR_W'(OQ_DEPTH));

    wsa_back #(
        .SLOT_W(SLOT_W),
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(fq_nonempty),
        .head_slot (fq_head[FQ_W-1 -: SLOT_W]),
        .head_work (work_t'(fq_head[$bits(work_t)-1:0])),
        .go        (go),
        .pop       (fq_pop),
        .res_valid (d_valid),
        .res       (d_res)
    );

    wsa_queue #(
        .WIDTH(OQ_W),
        .DEPTH(OQ_DEPTH)
    ) u_oq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (d_valid),
        .push_data(d_res),
        .pop      (out_xfer),
        .head     (oq_head),
        .nonempty (out_valid),
        .full     (oq_full),
        .count    (oq_count)
    );

    assign out_xfer        = out_valid && !out_stall;
    assign averaged_sample = oq_head.avg;
    assign frame_done      = oq_head.fend;

    always_comb
    begin
        credit_next = credit_reg;
        if (fq_pop && !out_xfer)
        begin
            credit_next = CR_W'(credit_reg + 1'b1);
        end
        else if (out_xfer && !fq_pop)
        begin
            credit_next = CR_W'(credit_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CR_W'(OQ_DEPTH))
        else $error("more results in flight than result slots");
    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count <= credit_reg)
        else $error("result queue holds more than was issued");
    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> !oq_full || out_xfer)
        else $error("result arrived with no room in result queue");
`endif

endmodule
